// ----- rtl/tdrs_pkg.sv -----
`default_nettype none
package tdrs_pkg;

	localparam int NUM_STAGES = 18;
	localparam int RES_DEPTH = 4;
	localparam logic [5:0] NO_SKIP = 6'd63;
	localparam logic [15:0] SLOT_TICKS_RST = 16'd10000;

	typedef enum logic [2:0] {
		ACT_NONE       = 3'd0,
		ACT_STORE      = 3'd1,
		ACT_TX         = 3'd2,
		ACT_RX_START   = 3'd3,
		ACT_BAD_LEVEL  = 3'd4,
		ACT_BAD_SOURCE = 3'd5,
		ACT_TX_ABORT   = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		CMD_TICK    = 2'd0,
		CMD_RX      = 2'd1,
		CMD_OUTCOME = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		OC_BUSY   = 2'd0,
		OC_SENT   = 2'd1,
		OC_FAILED = 2'd2
	} outcome_t;

	localparam logic REG_NODE_ID = 1'b0;
	localparam logic REG_SLOT_TICKS = 1'b1;

	// per stage: level, slot count, data level
	localparam logic [2:0] STAGE_LV [NUM_STAGES] = '{
		3'd0, 3'd1, 3'd0, 3'd2, 3'd2, 3'd1, 3'd0, 3'd3, 3'd3,
		3'd2, 3'd1, 3'd0, 3'd4, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};
	localparam logic [4:0] STAGE_NSLT [NUM_STAGES] = '{
		5'd2, 5'd10, 5'd2, 5'd10, 5'd20, 5'd25, 5'd2, 5'd10, 5'd20,
		5'd25, 5'd25, 5'd2, 5'd10, 5'd20, 5'd25, 5'd25, 5'd25, 5'd2};
	localparam logic [2:0] STAGE_DAT [NUM_STAGES] = '{
		3'd0, 3'd0, 3'd1, 3'd0, 3'd2, 3'd2, 3'd2, 3'd0, 3'd3,
		3'd3, 3'd3, 3'd3, 3'd0, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4};

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] time_now;
		logic [4:0]  rx_level;
		logic [8:0]  rx_slot;
		logic [15:0] rx_stamp;
		logic [31:0] rx_source;
		logic [1:0]  tx_outcome;
	} in_item_t;

	typedef struct packed {
		action_t    action;
		logic [4:0] buffer_index;
		logic [8:0] header_slot;
		logic [4:0] header_level;
		logic       last;
	} res_t;

	typedef struct packed {
		logic load;
		logic recv;
		logic set_origin_now;
		logic reset_cycle;
		logic clr_await;
		logic advance;
		logic drop_send;
		logic div_load;
		logic div_step;
		logic walk_step;
		logic prep;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic       awaiting;
		logic       in_sync;
		logic       root;
		logic [1:0] command;
		logic [1:0] outcome;
		logic       rx_accept;
		logic       need_prep;
		logic       walk_stop;
	} dp_stat_t;

endpackage
`default_nettype wire

// ----- rtl/tdrs_in_if.sv -----
`default_nettype none
interface tdrs_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] time_now;
	logic [4:0]  rx_level;
	logic [8:0]  rx_slot;
	logic [15:0] rx_stamp;
	logic [31:0] rx_source;
	logic [1:0]  tx_outcome;

	modport source(output valid, command, time_now, rx_level, rx_slot, rx_stamp, rx_source,
		tx_outcome, input ready);
	modport sink(input valid, command, time_now, rx_level, rx_slot, rx_stamp, rx_source,
		tx_outcome, output ready);
endinterface
`default_nettype wire

// ----- rtl/tdrs_out_if.sv -----
`default_nettype none
interface tdrs_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [4:0] buffer_index;
	logic [8:0] header_slot;
	logic [4:0] header_level;
	logic       last;

	modport source(output valid, action, buffer_index, header_slot, header_level, last,
		input ready);
	modport sink(input valid, action, buffer_index, header_slot, header_level, last,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/tdrs_res_fifo.sv -----
`default_nettype none
module tdrs_res_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tdrs_pkg::res_t push_data,
	output logic                room,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output tdrs_pkg::res_t      pop_data
);
	localparam int AW = $clog2(tdrs_pkg::RES_DEPTH);

	tdrs_pkg::res_t mem_q [tdrs_pkg::RES_DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   count_q;
	logic          pop;

	assign pop = pop_valid && pop_ready;
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rp_q];
	// an item emits at most three results
	assign room = (count_q <= (AW+1)'(tdrs_pkg::RES_DEPTH - 3));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && count_q == (AW+1)'(tdrs_pkg::RES_DEPTH)))
		else $error("result queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !pop)
		else $error("result queue underflow");
endmodule
`default_nettype wire

// ----- rtl/tdrs_ctrl.sv -----
`default_nettype none
module tdrs_ctrl #(
	parameter int MAX_WALK = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               room,
	input  wire tdrs_pkg::dp_stat_t stat,
	output tdrs_pkg::ctl_cmd_t      cmd
);
	localparam int GW = $clog2(MAX_WALK + 1);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_DISP  = 6'b000010,
		S_DIVLD = 6'b000100,
		S_DIV   = 6'b001000,
		S_WALK  = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [3:0] div_cnt_q;
	logic [GW-1:0] guard_q;
	logic guard_last;

	assign in_ready = (state_q == S_IDLE) && room;
	assign guard_last = (guard_q == GW'(MAX_WALK - 1));

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				state_d = S_FIN;
				if (stat.awaiting) begin
					if (stat.command == tdrs_pkg::CMD_RX) begin
						cmd.recv = 1'b1;
					end else if (stat.command == tdrs_pkg::CMD_OUTCOME) begin
						cmd.clr_await = 1'b1;
						if (stat.outcome == tdrs_pkg::OC_SENT) begin
							cmd.advance = 1'b1;
							state_d = S_DIVLD;
						end else if (stat.outcome != tdrs_pkg::OC_BUSY) begin
							cmd.drop_send = 1'b1;
						end
					end
				end else if (stat.command == tdrs_pkg::CMD_TICK ||
						stat.command == tdrs_pkg::CMD_RX) begin
					if (!stat.in_sync) begin
						if (stat.root) begin
							cmd.set_origin_now = 1'b1;
							cmd.reset_cycle = 1'b1;
							state_d = S_DIVLD;
						end else if (stat.command == tdrs_pkg::CMD_RX) begin
							cmd.recv = 1'b1;
							if (stat.rx_accept) begin
								cmd.reset_cycle = 1'b1;
								state_d = S_DIVLD;
							end
						end
					end else begin
						cmd.recv = (stat.command == tdrs_pkg::CMD_RX);
						state_d = S_DIVLD;
					end
				end
			end
			S_DIVLD: begin
				cmd.div_load = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == 4'd15) state_d = S_WALK;
			end
			S_WALK: begin
				if (stat.need_prep) begin
					cmd.prep = 1'b1;
				end else begin
					cmd.walk_step = 1'b1;
					if (stat.walk_stop || guard_last) state_d = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_cnt_q <= '0;
			guard_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIVLD) div_cnt_q <= '0;
			else if (state_q == S_DIV) div_cnt_q <= div_cnt_q + 4'd1;
			if (state_q != S_WALK) guard_q <= '0;
			else if (cmd.walk_step) guard_q <= guard_q + 1'b1;
		end
	end

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (guard_q <= GW'(MAX_WALK - 1)))
		else $error("walk ran past its bound");
	a_fin_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (state_q == S_IDLE))
		else $error("finish did not return to idle");
endmodule
`default_nettype wire

// ----- rtl/tdrs_dp.sv -----
`default_nettype none
module tdrs_dp #(
	parameter int NUM_BUFFERS = 21,
	parameter int GROUP_SIZE = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic               cfg_index,
	input  wire logic [15:0]        cfg_wdata,
	input  wire tdrs_pkg::in_item_t in_item,
	input  wire tdrs_pkg::ctl_cmd_t cmd,
	output tdrs_pkg::dp_stat_t      stat,
	output logic                    push,
	output tdrs_pkg::res_t          push_data
);
	localparam int BLW = $clog2(GROUP_SIZE + 1);
	localparam int NS = tdrs_pkg::NUM_STAGES;

	// constant tables that follow from the group size
	logic [5:0] mlv_tab [32];
	logic [2:0] md_tab [32];
	logic [4:0] nq_tab [NS];
	logic [5:0] sb_tab [NS];

	for (genvar i = 0; i < 32; i++) begin : g_node
		localparam int LV = (i + GROUP_SIZE - 1) / GROUP_SIZE;
		localparam int MD = (i == 0) ? 0 : ((i - 1) % GROUP_SIZE);
		assign mlv_tab[i] = 6'(LV);
		assign md_tab[i] = 3'(MD);
	end
	for (genvar g = 0; g < NS; g++) begin : g_stage
		localparam int NSL = int'(tdrs_pkg::STAGE_NSLT[g]);
		localparam int DAT = int'(tdrs_pkg::STAGE_DAT[g]);
		localparam int NQ = NSL / GROUP_SIZE;
		localparam int SB = (DAT == 0) ? 0 : (DAT * GROUP_SIZE - (GROUP_SIZE - 1));
		assign nq_tab[g] = 5'(NQ);
		assign sb_tab[g] = 6'(SB);
	end

	// configuration and scheduler state
	logic [4:0]     node_id_q;
	logic [15:0]    slot_ticks_q;
	logic           in_sync_q, prepared_q, sending_q, awaiting_q;
	logic [15:0]    origin_q;
	logic [4:0]     stage_q;
	logic [8:0]     base_q;
	logic [4:0]     send_level_q;
	logic [8:0]     send_slot_q;
	logic [4:0]     slots_total_q, slots_done_q;
	logic [5:0]     send_buffer_q;
	logic [BLW-1:0] buffers_left_q;
	logic [5:0]     skip_q;
	logic [1:0]     res_n_q;
	logic           pend_v_q;

	// item payload
	tdrs_pkg::in_item_t item_q;
	logic [15:0]    prod_q;
	logic [15:0]    cur_q;
	logic [15:0]    rem_q;
	tdrs_pkg::res_t pend_q;

	// receive check
	logic [5:0] mlv, lv6;
	logic parent, store_path, src_bad, rx_accept, parent_sync;

	assign mlv = mlv_tab[node_id_q];
	assign lv6 = {1'b0, item_q.rx_level};
	assign src_bad = (item_q.rx_source >= 32'(NUM_BUFFERS));

	always_comb begin
		parent = 1'b0;
		store_path = 1'b0;
		priority if (lv6 == 6'd0) begin
			parent = (mlv == 6'd1);
		end else if (lv6 < mlv) begin
			parent = ((mlv - lv6) == 6'd1);
		end else begin
			store_path = ((lv6 - mlv) <= 6'd1);
		end
	end

	assign parent_sync = !store_path && parent;
	assign rx_accept = (store_path && !src_bad) || parent_sync;

	// divider
	logic [15:0] tdiv;
	logic [16:0] rem_sh;
	logic [16:0] rem_nx;
	logic        rem_ge;

	assign tdiv = (slot_ticks_q == 16'd0) ? 16'd1 : slot_ticks_q;
	assign rem_sh = {rem_q, cur_q[15]};
	assign rem_ge = (rem_sh >= {1'b0, tdiv});
	assign rem_nx = rem_ge ? rem_sh - {1'b0, tdiv} : rem_sh;

	// walk step
	logic [4:0] sidx;
	logic       w_end, lt_start, lt_send, ge_end, tx_done, buf_bad;
	logic [9:0] end_slot;
	logic [5:0] buf_n;
	logic [2:0] st_lv;
	logic       lv_match;
	logic [7:0] slot_off;
	logic [9:0] prep_slot;

	assign w_end = (stage_q >= 5'(NS));
	assign sidx = w_end ? 5'd0 : stage_q;
	assign end_slot = {1'b0, base_q} + {5'b0, tdrs_pkg::STAGE_NSLT[sidx]};
	assign lt_start = (cur_q < {7'b0, base_q});
	assign lt_send = (cur_q < {7'b0, send_slot_q});
	assign ge_end = (cur_q >= {6'b0, end_slot});
	assign tx_done = (slots_done_q >= slots_total_q);
	assign buf_n = (skip_q != tdrs_pkg::NO_SKIP && send_buffer_q == skip_q) ?
		send_buffer_q + 6'd1 : send_buffer_q;
	assign buf_bad = (buf_n >= 6'(NUM_BUFFERS));
	assign st_lv = tdrs_pkg::STAGE_LV[sidx];
	assign lv_match = ({3'b0, st_lv} == mlv);
	assign slot_off = md_tab[node_id_q] * nq_tab[sidx];
	assign prep_slot = {1'b0, base_q} + {2'b0, slot_off};

	// advance after a sent outcome
	logic [4:0]     adv_done;
	logic [BLW-1:0] adv_left;
	assign adv_done = slots_done_q + 5'd1;
	assign adv_left = (buffers_left_q != '0) ? buffers_left_q - 1'b1 : buffers_left_q;

	logic walk_stop;
	logic emit_v;
	tdrs_pkg::res_t emit_r;

	always_comb begin
		walk_stop = 1'b1;
		emit_v = 1'b0;
		emit_r = '0;
		if (cmd.recv) begin
			if (store_path) begin
				emit_v = 1'b1;
				if (src_bad) begin
					emit_r.action = tdrs_pkg::ACT_BAD_SOURCE;
				end else begin
					emit_r.action = tdrs_pkg::ACT_STORE;
					emit_r.buffer_index = item_q.rx_source[4:0];
				end
			end else if (!parent) begin
				emit_v = 1'b1;
				emit_r.action = tdrs_pkg::ACT_BAD_LEVEL;
			end
		end
		if (cmd.advance && adv_done >= slots_total_q) begin
			emit_v = 1'b1;
			emit_r.action = tdrs_pkg::ACT_RX_START;
		end
		priority if (w_end) begin
			walk_stop = !(node_id_q == 5'd0);
			if (cmd.walk_step && node_id_q != 5'd0) begin
				emit_v = 1'b1;
				emit_r.action = tdrs_pkg::ACT_RX_START;
			end
		end else if (lt_start) begin
			walk_stop = 1'b1;
		end else if (sending_q) begin
			if (lt_send) begin
				walk_stop = 1'b1;
			end else if (tx_done) begin
				walk_stop = 1'b0;
				if (cmd.walk_step) begin
					emit_v = 1'b1;
					emit_r.action = tdrs_pkg::ACT_RX_START;
				end
			end else if (cmd.walk_step) begin
				emit_v = 1'b1;
				if (buf_bad) begin
					emit_r.action = tdrs_pkg::ACT_TX_ABORT;
				end else begin
					emit_r.action = tdrs_pkg::ACT_TX;
					emit_r.buffer_index = buf_n[4:0];
					emit_r.header_slot = send_slot_q;
					emit_r.header_level = send_level_q;
				end
			end
		end else begin
			walk_stop = !ge_end;
		end
	end

	always_comb begin
		stat.awaiting = awaiting_q;
		stat.in_sync = in_sync_q;
		stat.root = (node_id_q == 5'd0);
		stat.command = item_q.command;
		stat.outcome = item_q.tx_outcome;
		stat.rx_accept = rx_accept;
		stat.need_prep = !w_end && !lt_start && !prepared_q;
		stat.walk_stop = walk_stop;
	end

	always_comb begin
		push = 1'b0;
		push_data = pend_q;
		if (cmd.finish) begin
			push = 1'b1;
			if (pend_v_q) begin
				push_data.last = 1'b1;
			end else begin
				push_data = '0;
				push_data.last = 1'b1;
			end
		end else if (emit_v && res_n_q != 2'd3 && pend_v_q) begin
			push = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_item;
			prod_q <= 16'(in_item.rx_slot * slot_ticks_q);
		end
		if (cmd.div_load) begin
			cur_q <= item_q.time_now - origin_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			// restoring division, one quotient bit per cycle
			rem_q <= rem_nx[15:0];
			cur_q <= {cur_q[14:0], rem_ge};
		end else if (cmd.walk_step && w_end && node_id_q == 5'd0) begin
			cur_q <= '0;
		end
		if (emit_v && res_n_q != 2'd3) pend_q <= emit_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
			slot_ticks_q <= tdrs_pkg::SLOT_TICKS_RST;
			in_sync_q <= 1'b1;
			prepared_q <= 1'b0;
			sending_q <= 1'b0;
			awaiting_q <= 1'b0;
			origin_q <= '0;
			stage_q <= '0;
			base_q <= '0;
			send_level_q <= '0;
			send_slot_q <= '0;
			slots_total_q <= '0;
			slots_done_q <= '0;
			send_buffer_q <= '0;
			buffers_left_q <= '0;
			skip_q <= tdrs_pkg::NO_SKIP;
			res_n_q <= '0;
			pend_v_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == tdrs_pkg::REG_NODE_ID) begin
				node_id_q <= cfg_wdata[4:0];
				origin_q <= '0;
				in_sync_q <= (cfg_wdata[4:0] == 5'd0);
				prepared_q <= 1'b0;
				sending_q <= 1'b0;
				awaiting_q <= 1'b0;
				stage_q <= '0;
				base_q <= '0;
			end else begin
				slot_ticks_q <= cfg_wdata;
			end
		end else begin
			if (cmd.recv && parent_sync) origin_q <= item_q.rx_stamp - prod_q;
			if (cmd.set_origin_now) origin_q <= item_q.time_now;
			if (cmd.reset_cycle) begin
				in_sync_q <= 1'b1;
				prepared_q <= 1'b0;
				sending_q <= 1'b0;
				awaiting_q <= 1'b0;
				stage_q <= '0;
				base_q <= '0;
			end
			if (cmd.clr_await) awaiting_q <= 1'b0;
			if (cmd.drop_send) sending_q <= 1'b0;
			if (cmd.advance) begin
				slots_done_q <= adv_done;
				send_slot_q <= send_slot_q + 9'd1;
				buffers_left_q <= adv_left;
				if (adv_left != '0) send_buffer_q <= send_buffer_q + 6'd1;
				if (adv_done >= slots_total_q) sending_q <= 1'b0;
			end
			if (cmd.prep) begin
				prepared_q <= 1'b1;
				if (lv_match) begin
					send_level_q <= {2'b0, st_lv};
					slots_done_q <= '0;
					if (st_lv != 3'd0) begin
						slots_total_q <= nq_tab[sidx];
						send_slot_q <= prep_slot[8:0];
						sending_q <= (nq_tab[sidx] != 5'd0);
					end else begin
						slots_total_q <= tdrs_pkg::STAGE_NSLT[sidx];
						send_slot_q <= base_q;
						sending_q <= (tdrs_pkg::STAGE_NSLT[sidx] != 5'd0);
					end
					if (tdrs_pkg::STAGE_DAT[sidx] == 3'd0) begin
						send_buffer_q <= {1'b0, node_id_q};
						buffers_left_q <= BLW'(1);
						skip_q <= tdrs_pkg::NO_SKIP;
					end else begin
						send_buffer_q <= sb_tab[sidx];
						buffers_left_q <= BLW'(GROUP_SIZE);
						skip_q <= {1'b0, node_id_q};
					end
				end else begin
					sending_q <= 1'b0;
				end
			end
			if (cmd.walk_step) begin
				priority if (w_end) begin
					// root wraps the table, others fall out of sync
					in_sync_q <= (node_id_q == 5'd0);
					prepared_q <= 1'b0;
					sending_q <= 1'b0;
					awaiting_q <= 1'b0;
					stage_q <= '0;
					base_q <= '0;
					if (node_id_q == 5'd0) origin_q <= item_q.time_now;
				end else if (lt_start) begin
					in_sync_q <= in_sync_q;
				end else if (sending_q) begin
					if (!lt_send) begin
						if (tx_done) begin
							sending_q <= 1'b0;
						end else begin
							send_buffer_q <= buf_n;
							if (buf_bad) sending_q <= 1'b0;
							else awaiting_q <= 1'b1;
						end
					end
				end else if (ge_end) begin
					stage_q <= stage_q + 5'd1;
					base_q <= end_slot[8:0];
					prepared_q <= 1'b0;
				end
			end
			if (cmd.finish) begin
				res_n_q <= '0;
				pend_v_q <= 1'b0;
			end else if (emit_v && res_n_q != 2'd3) begin
				res_n_q <= res_n_q + 2'd1;
				pend_v_q <= 1'b1;
			end
		end
	end

	a_await_sending: assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_q |-> sending_q)
		else $error("waiting on an outcome with no transmission open");
	a_pend_count: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q == (res_n_q != 2'd0))
		else $error("held result and result count disagree");
endmodule
`default_nettype wire

// ----- rtl/tdma_relay_slot_scheduler.sv -----
`default_nettype none
// Channel  Dir  Beat
// in_ch    in   command, time_now, rx_level, rx_slot, rx_stamp, rx_source, tx_outcome
// out_ch   out  action, buffer_index, header_slot, header_level, last (1-3 beats per item)
// cfg      in   cfg_we / cfg_index / cfg_wdata, index 0 node_id, 1 slot_ticks
//
// An item that runs no table walk passes through accept, dispatch and finish.
// A walking item adds a divider load and the slot divider steps (one quotient bit per cycle),
// then walk steps and stage prepares, at most MAX_WALK walk steps.
// Results drain through a 4-entry queue; an item is taken once 3 entries are free.
// Asynchronous reset leaves node 0 in sync with slot_ticks 10000.
module tdma_relay_slot_scheduler #(
	parameter int NUM_BUFFERS = 21,
	parameter int GROUP_SIZE = 5,
	parameter int MAX_WALK = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	tdrs_in_if.sink          in_ch,
	tdrs_out_if.source       out_ch,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	tdrs_pkg::in_item_t in_item;
	tdrs_pkg::ctl_cmd_t cmd;
	tdrs_pkg::dp_stat_t stat;
	tdrs_pkg::res_t     push_data, pop_data;
	logic push, room;

	always_comb begin
		in_item.command = in_ch.command;
		in_item.time_now = in_ch.time_now;
		in_item.rx_level = in_ch.rx_level;
		in_item.rx_slot = in_ch.rx_slot;
		in_item.rx_stamp = in_ch.rx_stamp;
		in_item.rx_source = in_ch.rx_source;
		in_item.tx_outcome = in_ch.tx_outcome;
	end

	tdrs_ctrl #(.MAX_WALK(MAX_WALK)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.room     (room),
		.stat     (stat),
		.cmd      (cmd)
	);

	tdrs_dp #(.NUM_BUFFERS(NUM_BUFFERS), .GROUP_SIZE(GROUP_SIZE)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_item   (in_item),
		.cmd       (cmd),
		.stat      (stat),
		.push      (push),
		.push_data (push_data)
	);

	tdrs_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.room      (room),
		.pop_valid (out_ch.valid),
		.pop_ready (out_ch.ready),
		.pop_data  (pop_data)
	);

	assign out_ch.action = pop_data.action;
	assign out_ch.buffer_index = pop_data.buffer_index;
	assign out_ch.header_slot = pop_data.header_slot;
	assign out_ch.header_level = pop_data.header_level;
	assign out_ch.last = pop_data.last;

	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |-> room)
		else $error("item taken without queue room");
endmodule
`default_nettype wire

// ----- bench/tb_tdma_relay_slot_scheduler.sv -----
`timescale 1ns / 100ps
module tb_tdma_relay_slot_scheduler;
	import tdrs_pkg::*;

	localparam int N_BUF = 21;
	localparam int GRP = 5;
	localparam int WALK_LIMIT = 32;
	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam logic [1:0] OC_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_NODE_ID;
	logic [15:0] cfg_wdata = '0;

	tdrs_in_if in_ch ();
	tdrs_out_if out_ch ();

	tdma_relay_slot_scheduler u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	in_item_t pending_items[$];
	res_t expected_actions[$];
	res_t step_beats[$];
	int err_count = 0;
	bit calm = 1'b0;
	int hold_reqs = 0;
	int hold_done = 0;

	// scheduler mirror
	logic [4:0] m_node;
	logic [15:0] m_ticks;
	logic m_sync, m_prepared, m_sending, m_awaiting;
	logic [15:0] m_origin;
	logic [4:0] m_stage;
	logic [8:0] m_base;
	logic [4:0] m_send_level;
	logic [8:0] m_send_slot;
	logic [4:0] m_total, m_done;
	logic [5:0] m_buf;
	logic [2:0] m_left;
	logic [5:0] m_skip;

	function automatic void emit_action(action_t a, int b, int s, int l);
		res_t r;
		if (step_beats.size() >= 3)
			return;
		r.action = a;
		r.buffer_index = b[4:0];
		r.header_slot = s[8:0];
		r.header_level = l[4:0];
		r.last = 1'b0;
		step_beats.push_back(r);
	endfunction

	function automatic int my_level();
		return (int'(m_node) + GRP - 1) / GRP;
	endfunction

	function automatic int slot_at(logic [15:0] now);
		logic [15:0] d;
		d = now - m_origin;
		return int'(d) / (m_ticks == 0 ? 1 : int'(m_ticks));
	endfunction

	function automatic void restart_cycle(logic s);
		m_sync = s;
		m_prepared = 1'b0;
		m_sending = 1'b0;
		m_awaiting = 1'b0;
		m_stage = '0;
		m_base = '0;
	endfunction

	function automatic bit take_header(in_item_t it);
		int lv, mlv;
		bit parent;
		lv = it.rx_level;
		mlv = my_level();
		parent = 1'b0;
		if (lv == 0)
			parent = (mlv == 1);
		else if (lv < mlv)
			parent = (mlv - lv == 1);
		else if (lv - mlv <= 1) begin
			if (it.rx_source >= N_BUF) begin
				emit_action(ACT_BAD_SOURCE, 0, 0, 0);
				return 1'b0;
			end
			emit_action(ACT_STORE, int'(it.rx_source), 0, 0);
			return 1'b1;
		end
		if (!parent) begin
			emit_action(ACT_BAD_LEVEL, 0, 0, 0);
			return 1'b0;
		end
		m_origin = it.rx_stamp - 16'(it.rx_slot * m_ticks);
		return 1'b1;
	endfunction

	function automatic void prepare_stage();
		int lv, nslt, datlv, slt;
		lv = STAGE_LV[m_stage];
		nslt = STAGE_NSLT[m_stage];
		datlv = STAGE_DAT[m_stage];
		slt = m_base;
		m_prepared = 1'b1;
		m_sending = 1'b0;
		if (lv != my_level())
			return;
		if (lv != 0) begin
			nslt = nslt / GRP;
			slt = slt + ((int'(m_node) - 1) % GRP) * nslt;
		end
		m_send_level = lv;
		m_send_slot = slt;
		m_total = nslt;
		m_done = '0;
		if (datlv == 0) begin
			m_buf = m_node;
			m_left = 3'd1;
			m_skip = NO_SKIP;
		end else begin
			m_buf = datlv * GRP - (GRP - 1);
			m_left = GRP;
			m_skip = m_node;
		end
		if (m_total > 0)
			m_sending = 1'b1;
	endfunction

	function automatic bit send_next();
		if (m_done >= m_total) begin
			m_sending = 1'b0;
			emit_action(ACT_RX_START, 0, 0, 0);
			return 1'b1;
		end
		if (m_skip != NO_SKIP && m_buf == m_skip)
			m_buf++;
		if (m_buf >= N_BUF) begin
			m_sending = 1'b0;
			emit_action(ACT_TX_ABORT, 0, 0, 0);
			return 1'b0;
		end
		emit_action(ACT_TX, m_buf, m_send_slot, m_send_level);
		m_awaiting = 1'b1;
		return 1'b0;
	endfunction

	function automatic void walk_table(logic [15:0] now);
		int start, stop, cur;
		for (int g = 0; g < WALK_LIMIT; g++) begin
			if (m_stage >= NUM_STAGES) begin
				if (m_node == 0) begin
					m_origin = now;
					restart_cycle(1'b1);
					continue;
				end
				restart_cycle(1'b0);
				emit_action(ACT_RX_START, 0, 0, 0);
				return;
			end
			start = m_base;
			stop = start + STAGE_NSLT[m_stage];
			cur = slot_at(now);
			if (cur < start)
				return;
			if (!m_prepared)
				prepare_stage();
			if (m_sending) begin
				if (cur < m_send_slot)
					return;
				if (!send_next())
					return;
				continue;
			end
			if (cur >= stop) begin
				m_stage++;
				m_base = stop;
				m_prepared = 1'b0;
				continue;
			end
			return;
		end
	endfunction

	function automatic void schedule_reset();
		m_node = '0;
		m_ticks = SLOT_TICKS_RST;
		m_origin = '0;
		restart_cycle(1'b1);
		m_send_level = '0;
		m_send_slot = '0;
		m_total = '0;
		m_done = '0;
		m_buf = '0;
		m_left = '0;
		m_skip = NO_SKIP;
	endfunction

	function automatic void predict_item(in_item_t it);
		bit go;
		step_beats.delete();
		if (m_awaiting) begin
			if (it.command == CMD_RX)
				void'(take_header(it));
			else if (it.command == CMD_OUTCOME) begin
				m_awaiting = 1'b0;
				if (it.tx_outcome == OC_SENT) begin
					m_done++;
					m_send_slot++;
					if (m_left > 0)
						m_left--;
					if (m_left > 0)
						m_buf++;
					if (m_done >= m_total) begin
						m_sending = 1'b0;
						emit_action(ACT_RX_START, 0, 0, 0);
					end
					walk_table(it.time_now);
				end else if (it.tx_outcome != OC_BUSY) begin
					m_sending = 1'b0;
				end
			end
		end else if (it.command == CMD_TICK || it.command == CMD_RX) begin
			go = 1'b1;
			if (!m_sync) begin
				if (m_node == 0) begin
					m_origin = it.time_now;
					restart_cycle(1'b1);
				end else if (it.command == CMD_RX && take_header(it))
					restart_cycle(1'b1);
				else
					go = 1'b0;
			end else if (it.command == CMD_RX)
				void'(take_header(it));
			if (go)
				walk_table(it.time_now);
		end
		if (step_beats.size() == 0)
			emit_action(ACT_NONE, 0, 0, 0);
		step_beats[step_beats.size() - 1].last = 1'b1;
		foreach (step_beats[i])
			expected_actions.push_back(step_beats[i]);
	endfunction

	// driver
	in_item_t cur_item;
	int in_gap = 0;
	always @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			predict_item(cur_item);
		if (!in_ch.valid || in_ch.ready) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.command <= cur_item.command;
				in_ch.time_now <= cur_item.time_now;
				in_ch.rx_level <= cur_item.rx_level;
				in_ch.rx_slot <= cur_item.rx_slot;
				in_ch.rx_stamp <= cur_item.rx_stamp;
				in_ch.rx_source <= cur_item.rx_source;
				in_ch.tx_outcome <= cur_item.tx_outcome;
				if (!calm && $urandom_range(0, 7) == 0)
					in_gap <= $urandom_range(1, 14);
			end else
				in_ch.valid <= 1'b0;
		end
	end

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		err_count++;
	endtask

	// monitor
	int out_stall = 0;
	always @(posedge clk) begin
		res_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_actions.size() == 0)
				report("unexpected beat, action", out_ch.action, -1);
			else begin
				want = expected_actions.pop_front();
				if (out_ch.action !== want.action)
					report("action", out_ch.action, want.action);
				if (out_ch.buffer_index !== want.buffer_index)
					report("buffer_index", out_ch.buffer_index, want.buffer_index);
				if (out_ch.header_slot !== want.header_slot)
					report("header_slot", out_ch.header_slot, want.header_slot);
				if (out_ch.header_level !== want.header_level)
					report("header_level", out_ch.header_level, want.header_level);
				if (out_ch.last !== want.last)
					report("last", out_ch.last, want.last);
			end
		end
		if (hold_reqs != hold_done) begin
			hold_done <= hold_reqs;
			out_stall <= 400;
			out_ch.ready <= 1'b0;
		end else if (out_stall > 0) begin
			out_stall <= out_stall - 1;
			out_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_stall <= $urandom_range(0, 13);
			out_ch.ready <= 1'b0;
		end else
			out_ch.ready <= 1'b1;
	end

	task automatic write_reg(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_NODE_ID) begin
			m_node = val[4:0];
			m_origin = '0;
			restart_cycle(m_node == 0);
		end else
			m_ticks = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || in_ch.valid || expected_actions.size() != 0);
		repeat (120) @(posedge clk);
	endtask

	function automatic in_item_t make_item(logic [1:0] cmd, logic [15:0] now, int lv, int slt,
		logic [15:0] stamp, logic [31:0] src, logic [1:0] oc);
		in_item_t it;
		it.command = cmd;
		it.time_now = now;
		it.rx_level = lv[4:0];
		it.rx_slot = slt[8:0];
		it.rx_stamp = stamp;
		it.rx_source = src;
		it.tx_outcome = oc;
		return it;
	endfunction

	logic [15:0] clock_now;

	task automatic queue_random(int count, int node, int ticks);
		int pick, lv, mlv, step;
		logic [31:0] src;
		logic [1:0] oc;
		mlv = (node + GRP - 1) / GRP;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			step = $urandom_range(0, ticks * 2);
			clock_now = clock_now + 16'(step);
			if (pick < 50)
				pending_items.push_back(make_item(CMD_TICK, clock_now, 0, 0, 0, 0, 0));
			else if (pick < 78) begin
				oc = ($urandom_range(0, 9) < 7) ? OC_SENT : 2'($urandom_range(0, 3));
				pending_items.push_back(make_item(CMD_OUTCOME, clock_now, 0, 0, 0, 0, oc));
			end else if (pick < 97) begin
				lv = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
					: ((mlv > 0 ? mlv - 1 : 0) + $urandom_range(0, 2));
				src = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, N_BUF - 1);
				pending_items.push_back(make_item(CMD_RX, clock_now, lv,
					($urandom_range(0, 5) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 40),
					clock_now - 16'($urandom_range(0, ticks)), src, 2'($urandom_range(0, 3))));
			end else
				pending_items.push_back(make_item(CMD_SPARE, $urandom(), $urandom_range(0, 31),
					$urandom_range(0, 511), $urandom(), $urandom(), 2'($urandom_range(0, 3))));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.command = CMD_TICK;
		in_ch.time_now = '0;
		in_ch.rx_level = '0;
		in_ch.rx_slot = '0;
		in_ch.rx_stamp = '0;
		in_ch.rx_source = '0;
		in_ch.tx_outcome = OC_BUSY;
		out_ch.ready = 1'b0;
		clock_now = '0;
		schedule_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// root at reset values: field extremes, bad level and bad source, spare codes
		pending_items.push_back(make_item(CMD_TICK, 16'h0000, 0, 0, 0, 0, OC_BUSY));
		pending_items.push_back(make_item(CMD_TICK, 16'd25000, 0, 0, 0, 0, OC_BUSY));
		pending_items.push_back(make_item(CMD_OUTCOME, 16'd25000, 0, 0, 0, 0, OC_BUSY));
		pending_items.push_back(make_item(CMD_OUTCOME, 16'd25000, 0, 0, 0, 0, OC_SENT));
		pending_items.push_back(make_item(CMD_RX, 16'hFFFF, 0, 0, 16'hFFFF, 0, OC_BUSY));
		pending_items.push_back(make_item(CMD_RX, 16'hFFFF, 1, 511, 16'hFFFF, 32'd20, OC_BUSY));
		pending_items.push_back(make_item(CMD_RX, 16'h0, 1, 0, 16'h0, 32'd21, OC_SPARE));
		pending_items.push_back(make_item(CMD_RX, 16'h0, 31, 0, 16'h0, 32'hFFFF_FFFF, OC_BUSY));
		pending_items.push_back(make_item(CMD_SPARE, 16'hFFFF, 31, 511, 16'hFFFF,
			32'hFFFF_FFFF, OC_SPARE));
		pending_items.push_back(make_item(CMD_OUTCOME, 16'h0, 0, 0, 0, 0, OC_FAILED));
		pending_items.push_back(make_item(CMD_OUTCOME, 16'h0, 0, 0, 0, 0, OC_SPARE));
		wait_drained();

		// non-root: unsynced tick, parent sync, then walk into own stage
		write_reg(REG_NODE_ID, 16'd3);
		write_reg(REG_SLOT_TICKS, 16'd1);
		pending_items.push_back(make_item(CMD_TICK, 16'd5, 0, 0, 0, 0, OC_BUSY));
		pending_items.push_back(make_item(CMD_RX, 16'd9, 2, 0, 16'd9, 32'd4, OC_BUSY));
		pending_items.push_back(make_item(CMD_RX, 16'd10, 0, 3, 16'd10, 32'd0, OC_BUSY));
		pending_items.push_back(make_item(CMD_TICK, 16'd20, 0, 0, 0, 0, OC_BUSY));
		pending_items.push_back(make_item(CMD_OUTCOME, 16'd21, 0, 0, 0, 0, OC_BUSY));
		pending_items.push_back(make_item(CMD_TICK, 16'd22, 0, 0, 0, 0, OC_BUSY));
		pending_items.push_back(make_item(CMD_RX, 16'd22, 2, 0, 16'd22, 32'd7, OC_BUSY));
		pending_items.push_back(make_item(CMD_OUTCOME, 16'd23, 0, 0, 0, 0, OC_SENT));
		pending_items.push_back(make_item(CMD_OUTCOME, 16'd24, 0, 0, 0, 0, OC_SENT));
		pending_items.push_back(make_item(CMD_TICK, 16'd300, 0, 0, 0, 0, OC_BUSY));
		wait_drained();

		// random phases over node id and slot length
		write_reg(REG_NODE_ID, 16'd0);
		write_reg(REG_SLOT_TICKS, 16'd37);
		queue_random(70, 0, 37);
		hold_reqs = hold_reqs + 1;
		wait_drained();
		write_reg(REG_NODE_ID, 16'd20);
		write_reg(REG_SLOT_TICKS, 16'd3);
		queue_random(70, 20, 3);
		wait_drained();
		write_reg(REG_NODE_ID, 16'd7);
		write_reg(REG_SLOT_TICKS, 16'd1);
		queue_random(70, 7, 1);
		wait_drained();
		write_reg(REG_NODE_ID, 16'd1);
		write_reg(REG_SLOT_TICKS, 16'd65535);
		queue_random(30, 1, 65535);
		wait_drained();
		write_reg(REG_NODE_ID, 16'd12);
		write_reg(REG_SLOT_TICKS, 16'd5);
		queue_random(70, 12, 5);
		wait_drained();
		write_reg(REG_NODE_ID, 16'd16);
		write_reg(REG_SLOT_TICKS, 16'd2);
		queue_random(70, 16, 2);
		wait_drained();
		calm = 1'b1;
		write_reg(REG_NODE_ID, 16'd5);
		write_reg(REG_SLOT_TICKS, 16'd4);
		queue_random(70, 5, 4);
		wait_drained();

		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
